// ===== hw/rtl/sarpc_pkg.sv =====
package sarpc_pkg;

    // Number of LED channels: four RGB LEDs, three channels each.
    localparam int NUM_CH = 12;
    // Longest command is fourteen bytes; the last one is never stored.
    localparam int CMD_DEPTH = 13;
    localparam int CMD_IDX_W = $clog2(CMD_DEPTH);
    localparam int PWM_PERIOD = 64;
    localparam int PHASE_W = $clog2(PWM_PERIOD);
    localparam logic [7:0] BROADCAST_ADDR = 8'd255;
    localparam logic [7:0] DUTY_RESET = 8'd1;

    // Command codes, taken from the high nibble of a command's first byte.
    typedef enum logic [3:0] {
        CMD_SET_EXP     = 4'd1,
        CMD_SET_EXP_RGB = 4'd2,
        CMD_SAVE        = 4'd3,
        CMD_LOAD        = 4'd4,
        CMD_GET_ADDR    = 4'd5,
        CMD_SET_ADDR    = 4'd6,
        CMD_SELF_TEST   = 4'd7,
        CMD_SET_RAW     = 4'd8,
        CMD_SET_RAW_RGB = 4'd9
    } cmd_t;

    typedef struct packed {
        logic       action;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic              echo_valid;
        logic [7:0]        echo_byte;
        logic              reply_valid;
        logic [7:0]        reply_byte;
        logic [NUM_CH-1:0] led_levels;
    } out_item_t;

    // Total command length in bytes, including the trailing address byte.
    function automatic logic [3:0] cmd_length(input logic [3:0] code);
        logic [3:0] len;
        begin
            case (cmd_t'(code))
                CMD_SET_EXP:     len = 4'd8;
                CMD_SET_EXP_RGB: len = 4'd3;
                CMD_SAVE:        len = 4'd2;
                CMD_LOAD:        len = 4'd2;
                CMD_GET_ADDR:    len = 4'd2;
                CMD_SET_ADDR:    len = 4'd3;
                CMD_SELF_TEST:   len = 4'd2;
                CMD_SET_RAW:     len = 4'd14;
                CMD_SET_RAW_RGB: len = 4'd5;
                default:         len = 4'd1;
            endcase
            return len;
        end
    endfunction

    // Roughly exponential brightness curve for 4-bit intensity codes.
    function automatic logic [7:0] exp_level(input logic [3:0] code);
        logic [7:0] lvl;
        begin
            case (code)
                4'd0:    lvl = 8'd0;
                4'd1:    lvl = 8'd1;
                4'd2:    lvl = 8'd2;
                4'd3:    lvl = 8'd3;
                4'd4:    lvl = 8'd5;
                4'd5:    lvl = 8'd7;
                4'd6:    lvl = 8'd10;
                4'd7:    lvl = 8'd13;
                4'd8:    lvl = 8'd17;
                4'd9:    lvl = 8'd22;
                4'd10:   lvl = 8'd27;
                4'd11:   lvl = 8'd33;
                4'd12:   lvl = 8'd39;
                4'd13:   lvl = 8'd47;
                4'd14:   lvl = 8'd55;
                default: lvl = 8'd64;
            endcase
            return lvl;
        end
    endfunction

endpackage

// ===== hw/rtl/sarpc_engine.sv =====
module sarpc_engine (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  sarpc_pkg::in_item_t item,
    output sarpc_pkg::out_item_t result
);
    import sarpc_pkg::*;

    logic [7:0]         duty_reg  [NUM_CH];
    logic [7:0]         duty_next [NUM_CH];
    logic [7:0]         saved_reg  [NUM_CH];
    logic [7:0]         saved_next [NUM_CH];
    logic [7:0]         cmd_reg  [CMD_DEPTH];
    logic [7:0]         cmd_next [CMD_DEPTH];
    logic [7:0]         node_addr_reg;
    logic [7:0]         node_addr_next;
    logic [PHASE_W-1:0] phase_reg;
    logic [PHASE_W-1:0] phase_next;
    logic [3:0]         pos_reg;
    logic [3:0]         pos_next;
    logic [NUM_CH-1:0]  pins_reg;
    logic [NUM_CH-1:0]  pins_next;

    logic [3:0] pos;
    logic [7:0] first_byte;
    logic [3:0] len;
    logic       is_last;
    logic       run_cmd;
    logic       hit;
    logic       reply;

    // A corrupt position restarts the parser at the command byte.
    assign pos        = (pos_reg >= 4'd14) ? 4'd0 : pos_reg;
    assign first_byte = (pos == 4'd0) ? item.rx_byte : cmd_reg[0];
    assign len        = cmd_length(first_byte[7:4]);
    assign is_last    = ({1'b0, pos} + 5'd1) >= {1'b0, len};
    assign run_cmd    = is_last && (len != 4'd1);
    assign hit        = (item.rx_byte == BROADCAST_ADDR) || (item.rx_byte == node_addr_reg);

    always_comb
    begin
        duty_next      = duty_reg;
        saved_next     = saved_reg;
        cmd_next       = cmd_reg;
        node_addr_next = node_addr_reg;
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        pins_next      = pins_reg;
        reply          = 1'b0;
        if (fire)
        begin
            if (item.action)
            begin
                for (int i = 0; i < NUM_CH; i++)
                begin
                    pins_next[i] = duty_reg[i] > {{(8-PHASE_W){1'b0}}, phase_reg};
                end
                if (phase_reg == PHASE_W'(PWM_PERIOD - 1))
                begin
                    phase_next = '0;
                end
                else
                begin
                    phase_next = phase_reg + PHASE_W'(1);
                end
            end
            else
            begin
                if (!run_cmd)
                begin
                    cmd_next[pos[CMD_IDX_W-1:0]] = item.rx_byte;
                end
                pos_next = is_last ? 4'd0 : pos + 4'd1;
                if (run_cmd && hit)
                begin
                    case (cmd_t'(cmd_reg[0][7:4]))
                        CMD_SET_EXP:
                        begin
                            for (int i = 0; i < 6; i++)
                            begin
                                duty_next[2*i]   = exp_level(cmd_reg[i+1][7:4]);
                                duty_next[2*i+1] = exp_level(cmd_reg[i+1][3:0]);
                            end
                        end
                        CMD_SET_EXP_RGB:
                        begin
                            for (int k = 0; k < 4; k++)
                            begin
                                duty_next[3*k]   = exp_level(cmd_reg[0][3:0]);
                                duty_next[3*k+1] = exp_level(cmd_reg[1][7:4]);
                                duty_next[3*k+2] = exp_level(cmd_reg[1][3:0]);
                            end
                        end
                        CMD_SAVE:
                        begin
                            saved_next = duty_reg;
                        end
                        CMD_LOAD:
                        begin
                            duty_next = saved_reg;
                        end
                        CMD_GET_ADDR:
                        begin
                            reply = 1'b1;
                        end
                        CMD_SET_ADDR:
                        begin
                            if (node_addr_reg == 8'd0)
                            begin
                                node_addr_next = cmd_reg[1];
                            end
                        end
                        CMD_SET_RAW:
                        begin
                            for (int i = 0; i < NUM_CH; i++)
                            begin
                                duty_next[i] = cmd_reg[i+1];
                            end
                        end
                        CMD_SET_RAW_RGB:
                        begin
                            for (int k = 0; k < 4; k++)
                            begin
                                duty_next[3*k]   = cmd_reg[1];
                                duty_next[3*k+1] = cmd_reg[2];
                                duty_next[3*k+2] = cmd_reg[3];
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
        end
    end

    always_comb
    begin
        result.echo_valid  = !item.action;
        result.echo_byte   = item.action ? 8'd0 : item.rx_byte;
        result.reply_valid = reply;
        result.reply_byte  = reply ? node_addr_reg : 8'd0;
        result.led_levels  = pins_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CH; i++)
            begin
                duty_reg[i]  <= DUTY_RESET;
                saved_reg[i] <= DUTY_RESET;
            end
            node_addr_reg <= 8'd0;
            phase_reg     <= '0;
            pos_reg       <= 4'd0;
            pins_reg      <= '0;
        end
        else
        begin
            duty_reg      <= duty_next;
            saved_reg     <= saved_next;
            node_addr_reg <= node_addr_next;
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            pins_reg      <= pins_next;
        end
    end

    // Command byte storage needs no reset: each entry is written before use.
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

endmodule

// ===== hw/rtl/serial_addressed_rgb_pwm_controller.sv =====
// Twelve-channel RGB PWM controller driven by serial bytes. Each item is
// either a received byte or a PWM timer tick, and every item yields exactly
// one result item. Bytes are echoed and parsed as addressed commands; a
// get-address command aimed at this node also returns the node address.
// A tick updates the twelve LED levels and advances the PWM phase, which
// counts through 64 steps. The block takes one item per clock cycle unless
// the result side stalls; each item is held in the input register and its
// result is then taken into the result register. The parser and duty
// update are a single pass of logic between those two registers, and the
// result register holds a stalled result while the next item already
// waits in the input register.
module serial_addressed_rgb_pwm_controller (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  sarpc_pkg::in_item_t  item_data,
    output logic                 result_valid,
    input  logic                 result_stall,
    output sarpc_pkg::out_item_t result_data
);
    import sarpc_pkg::*;

    logic      in_valid_reg;
    logic      in_valid_next;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    logic      out_valid_next;
    out_item_t out_item_reg;
    out_item_t engine_result;
    logic      advance;
    logic      accept;

    // The held item moves on whenever the result register is free or is
    // being emptied in this cycle.
    assign advance    = in_valid_reg && (!out_valid_reg || !result_stall);
    assign item_stall = in_valid_reg && !advance;
    assign accept     = item_valid && !item_stall;

    sarpc_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (in_item_reg),
        .result (engine_result)
    );

    always_comb
    begin
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end

        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_item_reg <= item_data;
        end
        if (advance)
        begin
            out_item_reg <= engine_result;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_item_reg;

endmodule

// ===== tb/serial_addressed_rgb_pwm_controller_test.sv =====
`timescale 1ns / 1ps

module serial_addressed_rgb_pwm_controller_test;

    import sarpc_pkg::*;

    // A generous bound on the whole run. The slowest correct run sends about
    // two thousand items, each delayed by the longest sender gap and the
    // longest receiver stall, which is still far below this count.
    localparam int CYCLE_LIMIT = 2000000;
    localparam int RANDOM_ITEMS = 1800;
    // Cycles allowed after the last result, well above the block's latency.
    localparam int SETTLE_CYCLES = 12;
    // Brightness curve for 4-bit intensity codes; entry k sits at bits 8k+7:8k.
    localparam logic [16*8-1:0] BRIGHTNESS = {
        8'd64, 8'd55, 8'd47, 8'd39, 8'd33, 8'd27, 8'd22, 8'd17,
        8'd13, 8'd10, 8'd7, 8'd5, 8'd3, 8'd2, 8'd1, 8'd0
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_stall;
    in_item_t item_data = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    out_item_t result_data;

    // Items waiting to be sent, and the results that the sent items must cause.
    in_item_t byte_tick_queue[$];
    out_item_t reply_and_level_q[$];

    int cycle_count = 0;
    int error_count = 0;
    int queued_count = 0;
    // The node address the generator believes the block holds; some commands
    // are steered toward it so that they are accepted.
    logic [7:0] target_addr = 8'h00;

    // Shadow of the controller state, updated once per accepted item.
    logic [7:0] duty [NUM_CH];
    logic [7:0] stored_duty [NUM_CH];
    logic [7:0] node_id;
    logic [7:0] stored_id;
    logic [PHASE_W-1:0] phase;
    logic [7:0] cmd_buf [CMD_DEPTH];
    logic [3:0] cmd_pos;
    logic [NUM_CH-1:0] pins;

    serial_addressed_rgb_pwm_controller dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item_data    (item_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Number of bytes in a command, address byte included, by its code.
    function automatic int command_size(input logic [3:0] code);
        begin
            case (cmd_t'(code))
                CMD_SET_EXP:     return 8;
                CMD_SET_EXP_RGB: return 3;
                CMD_SAVE:        return 2;
                CMD_LOAD:        return 2;
                CMD_GET_ADDR:    return 2;
                CMD_SET_ADDR:    return 3;
                CMD_SELF_TEST:   return 2;
                CMD_SET_RAW:     return 14;
                CMD_SET_RAW_RGB: return 5;
                default:         return 1;
            endcase
        end
    endfunction

    function automatic logic [7:0] brightness(input logic [3:0] code);
        begin
            return BRIGHTNESS[code * 8 +: 8];
        end
    endfunction

    // Applies one item to the shadow state and returns the result it causes.
    function automatic out_item_t controller_step(input in_item_t it);
        out_item_t res;
        logic [NUM_CH-1:0] lv;
        logic [7:0] b;
        logic reply;
        int pos;
        int len;
        begin
            res = '0;
            reply = 1'b0;
            b = it.rx_byte;
            if (it.action) begin
                // A tick compares every duty against the current phase, so
                // a duty of the period or more keeps its channel always on.
                lv = '0;
                for (int i = 0; i < NUM_CH; i++)
                    lv[i] = duty[i] > 8'(phase);
                pins = lv;
                phase = (phase == PHASE_W'(PWM_PERIOD - 1)) ? '0 : phase + 1'b1;
                res.led_levels = pins;
                return res;
            end
            pos = cmd_pos;
            if (pos >= 14)
                pos = 0;
            len = (pos == 0) ? command_size(b[7:4]) : command_size(cmd_buf[0][7:4]);
            if (pos + 1 >= len) begin
                if (len == 1) begin
                    // Unknown codes make a one-byte command that does nothing.
                    cmd_buf[0] = b;
                end else if (b == BROADCAST_ADDR || b == node_id) begin
                    case (cmd_t'(cmd_buf[0][7:4]))
                        CMD_SET_EXP:
                            for (int i = 0; i < 6; i++) begin
                                duty[2 * i] = brightness(cmd_buf[i + 1][7:4]);
                                duty[2 * i + 1] = brightness(cmd_buf[i + 1][3:0]);
                            end
                        CMD_SET_EXP_RGB:
                            for (int k = 0; k < 4; k++) begin
                                duty[3 * k] = brightness(cmd_buf[0][3:0]);
                                duty[3 * k + 1] = brightness(cmd_buf[1][7:4]);
                                duty[3 * k + 2] = brightness(cmd_buf[1][3:0]);
                            end
                        CMD_SAVE:
                            stored_duty = duty;
                        CMD_LOAD:
                            duty = stored_duty;
                        CMD_GET_ADDR:
                            reply = 1'b1;
                        CMD_SET_ADDR:
                            // The address can only be set while it is still zero.
                            if (node_id == 8'h00) begin
                                stored_id = cmd_buf[1];
                                node_id = stored_id;
                            end
                        CMD_SET_RAW:
                            for (int i = 0; i < NUM_CH; i++)
                                duty[i] = cmd_buf[i + 1];
                        CMD_SET_RAW_RGB:
                            for (int k = 0; k < 4; k++) begin
                                duty[3 * k] = cmd_buf[1];
                                duty[3 * k + 1] = cmd_buf[2];
                                duty[3 * k + 2] = cmd_buf[3];
                            end
                        default:
                            ;
                    endcase
                end
                cmd_pos = '0;
            end else begin
                cmd_buf[pos] = b;
                cmd_pos = 4'(pos + 1);
            end
            res.echo_valid = 1'b1;
            res.echo_byte = b;
            res.reply_valid = reply;
            res.reply_byte = reply ? node_id : 8'h00;
            res.led_levels = pins;
            return res;
        end
    endfunction

    // Idle length for either side: mostly none or short, now and then long.
    // Periodically there is a stretch with no idling at all.
    function automatic int pick_pause();
        int r;
        begin
            r = $urandom_range(99);
            if ((cycle_count % 3000) < 400)
                return 0;
            if (r < 65)
                return 0;
            if (r < 90)
                return $urandom_range(1, 3);
            if (r < 98)
                return $urandom_range(4, 12);
            return $urandom_range(20, 60);
        end
    endfunction

    // Address byte for a command: mostly broadcast or this node, sometimes
    // a stranger so that whole commands are swallowed without effect.
    function automatic logic [7:0] pick_target();
        int r;
        begin
            r = $urandom_range(99);
            if (r < 40)
                return BROADCAST_ADDR;
            if (r < 75)
                return target_addr;
            if (r < 95)
                return 8'($urandom_range(255));
            return 8'h00;
        end
    endfunction

    task automatic push_item(input logic action, input logic [7:0] b);
        in_item_t it;
        begin
            it.action = action;
            it.rx_byte = b;
            byte_tick_queue.push_back(it);
            queued_count++;
        end
    endtask

    // Queues one command with random content. Ticks are sprinkled between
    // its bytes; a broken command stops short of its address byte.
    task automatic queue_command(input bit broken);
        logic [3:0] code;
        logic [7:0] addr;
        logic [7:0] new_addr;
        int len;
        int sent;
        int pick;
        begin
            if ($urandom_range(99) < 90) begin
                code = 4'($urandom_range(1, 9));
            end else begin
                pick = $urandom_range(0, 6);
                code = (pick == 0) ? 4'd0 : 4'(9 + pick);
            end
            len = command_size(code);
            sent = (broken && len > 1) ? $urandom_range(1, len - 1) : len;
            addr = pick_target();
            new_addr = 8'($urandom_range(255));
            for (int i = 0; i < sent; i++) begin
                if (i == 0)
                    push_item(1'b0, {code, 4'($urandom_range(15))});
                else if (i == len - 1)
                    push_item(1'b0, addr);
                else if (i == 1 && cmd_t'(code) == CMD_SET_ADDR)
                    push_item(1'b0, new_addr);
                else
                    push_item(1'b0, 8'($urandom_range(255)));
                if ($urandom_range(99) < 15)
                    push_item(1'b1, 8'($urandom_range(255)));
            end
            if (!broken && cmd_t'(code) == CMD_SET_ADDR && target_addr == 8'h00
                    && (addr == BROADCAST_ADDR || addr == 8'h00))
                target_addr = new_addr;
        end
    endtask

    // Holds the sender back until every queued item has gone out and every
    // expected result has arrived.
    task automatic wait_for_drain();
        begin
            while (byte_tick_queue.size() != 0 || item_valid
                    || reply_and_level_q.size() != 0)
                @(negedge clk);
        end
    endtask

    task automatic compare_field(input string name, input logic [11:0] want,
                                 input logic [11:0] got);
        begin
            if (want !== got) begin
                $error("%s mismatch: expected %0h, actual %0h", name, want, got);
                error_count++;
            end
        end
    endtask

    // Driver: presents queued items one at a time, holds an item while the
    // block stalls it, and predicts the result of every item it hands over.
    always @(posedge clk or negedge rst_n)
    begin : drive
        int send_gap;
        in_item_t nxt;
        logic nv;
        if (!rst_n) begin
            item_valid <= 1'b0;
            item_data <= '0;
            send_gap = 0;
            for (int i = 0; i < NUM_CH; i++) begin
                duty[i] = DUTY_RESET;
                stored_duty[i] = DUTY_RESET;
            end
            for (int i = 0; i < CMD_DEPTH; i++)
                cmd_buf[i] = 8'h00;
            node_id = 8'h00;
            stored_id = 8'h00;
            phase = '0;
            cmd_pos = '0;
            pins = '0;
        end else begin
            if (item_valid && !item_stall)
                reply_and_level_q.push_back(controller_step(item_data));
            // A stalled item stays on the bus unchanged.
            if (!(item_valid && item_stall)) begin
                nv = 1'b0;
                nxt = item_data;
                if (send_gap > 0) begin
                    send_gap--;
                end else if (byte_tick_queue.size() != 0) begin
                    nxt = byte_tick_queue.pop_front();
                    nv = 1'b1;
                    send_gap = pick_pause();
                end
                item_valid <= nv;
                item_data <= nxt;
            end
        end
    end

    // Monitor: takes results when not stalling and checks each one against
    // the oldest prediction. It also decides the stall for the next cycle.
    always @(posedge clk or negedge rst_n)
    begin : watch
        int hold;
        out_item_t want;
        if (!rst_n) begin
            result_stall <= 1'b0;
            hold = 0;
        end else begin
            if (result_valid && !result_stall) begin
                if (reply_and_level_q.size() == 0) begin
                    $error("result item arrived with nothing expected: %h", result_data);
                    error_count++;
                end else begin
                    want = reply_and_level_q.pop_front();
                    compare_field("echo_valid", 12'(want.echo_valid),
                                  12'(result_data.echo_valid));
                    compare_field("echo_byte", 12'(want.echo_byte),
                                  12'(result_data.echo_byte));
                    compare_field("reply_valid", 12'(want.reply_valid),
                                  12'(result_data.reply_valid));
                    compare_field("reply_byte", 12'(want.reply_byte),
                                  12'(result_data.reply_byte));
                    compare_field("led_levels", want.led_levels, result_data.led_levels);
                end
            end
            if (hold == 0)
                hold = pick_pause();
            if (hold > 0) begin
                hold--;
                result_stall <= 1'b1;
            end else begin
                result_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        int random_start;
        int r;
        bit mid_drained;
        mid_drained = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part. The first tick shows every channel on at phase zero,
        // since all duties come out of reset at one.
        push_item(1'b1, 8'hFF);
        // Shared brightness codes at both extremes, broadcast.
        push_item(1'b0, 8'h2F);
        push_item(1'b0, 8'h0F);
        push_item(1'b0, 8'hFF);
        push_item(1'b1, 8'h00);
        // Get-address aimed at another node is swallowed without a reply.
        push_item(1'b0, 8'h50);
        push_item(1'b0, 8'h33);
        // Set the address while it is still zero, addressed to node zero.
        push_item(1'b0, 8'h60);
        push_item(1'b0, 8'h5A);
        push_item(1'b0, 8'h00);
        target_addr = 8'h5A;
        // Get-address to the new address gives a reply.
        push_item(1'b0, 8'h57);
        push_item(1'b0, 8'h5A);
        // Save the current duties.
        push_item(1'b0, 8'h30);
        push_item(1'b0, 8'hFF);
        // Raw shared duties with a tick in the middle of the command; duties of
        // the period or more keep red and blue always on.
        push_item(1'b0, 8'h90);
        push_item(1'b0, 8'hFF);
        push_item(1'b1, 8'h5A);
        push_item(1'b0, 8'h00);
        push_item(1'b0, 8'h80);
        push_item(1'b0, 8'hFF);
        push_item(1'b1, 8'h00);
        // Load the saved duties back.
        push_item(1'b0, 8'h4F);
        push_item(1'b0, 8'h5A);
        // Self test, then the two extreme unknown codes.
        push_item(1'b0, 8'h70);
        push_item(1'b0, 8'hFF);
        push_item(1'b0, 8'h00);
        push_item(1'b0, 8'hFF);
        wait_for_drain();

        // Random part: mostly well-formed commands, with tick bursts, noise
        // bytes and commands cut short mixed in. Halfway through, the sender
        // stops until the block has caught up completely.
        random_start = queued_count;
        while (queued_count - random_start < RANDOM_ITEMS) begin
            if (!mid_drained && queued_count - random_start >= RANDOM_ITEMS / 2) begin
                wait_for_drain();
                mid_drained = 1'b1;
            end
            r = $urandom_range(99);
            if (r < 3) begin
                // A long burst sweeps the phase through a full period.
                repeat ($urandom_range(64, 80)) push_item(1'b1, 8'($urandom_range(255)));
            end else if (r < 25) begin
                repeat ($urandom_range(1, 4)) push_item(1'b1, 8'($urandom_range(255)));
            end else if (r < 85) begin
                queue_command(1'b0);
            end else if (r < 93) begin
                push_item(1'b0, 8'($urandom_range(255)));
            end else begin
                queue_command(1'b1);
            end
        end
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/sarpc_pkg.sv
hw/rtl/sarpc_engine.sv
hw/rtl/serial_addressed_rgb_pwm_controller.sv
tb/serial_addressed_rgb_pwm_controller_test.sv
